[rtl/iarr_pkg.sv]
// ============================================================================
// Image right-angle rotator package
// Shared request and response types, register indexes and rotation codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package iarr_pkg;

   // Default frame store dimensions.
   localparam int DEF_MAX_WIDTH    = 128;
   localparam int DEF_MAX_HEIGHT   = 128;
   localparam int DEF_MAX_CHANNELS = 4;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;

   // Cycles of setup after reset or a register write, while products settle.
   localparam int SETUP_CYCLES = 2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION_MODE = 2'd3;

   // Rotation codes; the spare code behaves as a quarter turn.
   localparam logic [1:0] ROT_90  = 2'd0;
   localparam logic [1:0] ROT_180 = 2'd1;
   localparam logic [1:0] ROT_270 = 2'd2;

   // Request function codes.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] sample;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       last_byte;
   } rsp_type;

   // Control from the top level to the load address generator.
   typedef struct packed {
      logic load;     // a load request is accepted this cycle
      logic restart;  // a register write restarts the frame
      logic reload;   // setup in progress: reload the start addresses
   } ldc_type;

   // Status from the load address generator.
   typedef struct packed {
      logic frame_done;  // the accepted load is the final byte of the frame
   } lds_type;

endpackage

`default_nettype wire

[rtl/iarr_ram.sv]
// ============================================================================
// Generic RAM
// One write port and one read port, with the read data registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module iarr_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire  logic              clock,
   input  wire  logic              wr_en,
   input  wire  logic [ADDR_W-1:0] wr_addr,
   input  wire  logic [DATA_W-1:0] wr_data,
   input  wire  logic              rd_en,
   input  wire  logic [ADDR_W-1:0] rd_addr,
   output logic       [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/iarr_load_addr.sv]
// ============================================================================
// Load address generator
// Walks the source raster with column, row and channel counters and keeps the
// rotated pixel index up to date by steps, giving the frame store write address.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module iarr_load_addr #(
   parameter int MAX_WIDTH    = iarr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = iarr_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_CHANNELS = iarr_pkg::DEF_MAX_CHANNELS,
   localparam int DIM_W_W = $clog2(MAX_WIDTH + 1),
   localparam int DIM_H_W = $clog2(MAX_HEIGHT + 1),
   localparam int CNT_W   = $clog2(MAX_CHANNELS + 1),
   localparam int WH_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS,
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire  logic                clock,
   input  wire  logic                reset,
   input  wire  iarr_pkg::ldc_type   ctl,
   input  wire  logic [DIM_W_W-1:0]  width,
   input  wire  logic [DIM_H_W-1:0]  height,
   input  wire  logic [CNT_W-1:0]    chans,
   input  wire  logic [1:0]          mode,
   input  wire  logic [WH_W-1:0]     area,
   output iarr_pkg::lds_type         status,
   output logic       [ADDR_W-1:0]   wr_addr
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CHN_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int PIX_W  = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                           $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
   localparam int PROD_W = PIX_W + CNT_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CHN_W-1:0] chan_ff, chan_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [PIX_W-1:0] rs_ff, rs_in;

   logic              chan_end, col_end, row_end;
   logic [WH_W-1:0]   pix_w, rs_w, h_w;
   logic [WH_W-1:0]   pix_init, rs_init, col_next, row_next;
   logic [PROD_W-1:0] prod;

   // End-of-span flags for the three counters.
   always_comb begin
      chan_end = (CNT_W'(chan_ff) == chans - CNT_W'(1));
      col_end  = (DIM_W_W'(col_ff) == width - DIM_W_W'(1));
      row_end  = (DIM_H_W'(row_ff) == height - DIM_H_W'(1));
      status.frame_done = ctl.load && chan_end && col_end && row_end;
   end

   // Start index and the steps along a row and down to the next row.
   always_comb begin
      pix_w = WH_W'(pix_ff);
      rs_w  = WH_W'(rs_ff);
      h_w   = WH_W'(height);
      if (mode == iarr_pkg::ROT_180) begin
         pix_init = area - WH_W'(1);
         rs_init  = area - WH_W'(1);
         col_next = pix_w - WH_W'(1);
         row_next = pix_w - WH_W'(1);
      end else if (mode == iarr_pkg::ROT_270) begin
         pix_init = area - h_w;
         rs_init  = area - h_w;
         col_next = pix_w - h_w;
         row_next = rs_w + WH_W'(1);
      end else begin
         // Quarter turn clockwise; the spare code behaves the same.
         pix_init = h_w - WH_W'(1);
         rs_init  = h_w - WH_W'(1);
         col_next = pix_w + h_w;
         row_next = rs_w - WH_W'(1);
      end
   end

   // Next values of the counters and the rotated pixel index.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      chan_in = chan_ff;
      pix_in  = pix_ff;
      rs_in   = rs_ff;
      if (ctl.restart) begin
         col_in  = '0;
         row_in  = '0;
         chan_in = '0;
      end else if (ctl.load) begin
         if (!chan_end) begin
            chan_in = chan_ff + CHN_W'(1);
         end else begin
            chan_in = '0;
            if (!col_end) begin
               col_in = col_ff + COL_W'(1);
               pix_in = PIX_W'(col_next);
            end else begin
               col_in = '0;
               pix_in = PIX_W'(row_next);
               rs_in  = PIX_W'(row_next);
               row_in = row_end ? '0 : row_ff + ROW_W'(1);
            end
         end
      end
      // Setup and the end of a frame both return to the start index.
      if (ctl.reload || status.frame_done) begin
         pix_in = PIX_W'(pix_init);
         rs_in  = PIX_W'(rs_init);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         chan_ff <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      rs_ff  <= rs_in;
   end

   // Byte address of the current load: pixel index times channels plus channel.
   always_comb begin
      prod    = PROD_W'(pix_ff) * PROD_W'(chans) + PROD_W'(chan_ff);
      wr_addr = ADDR_W'(prod);
   end

endmodule

`default_nettype wire

[rtl/image_right_angle_rotator_unit.sv]
// ============================================================================
// Image right-angle rotator
// Loads an interleaved 8-bit image into a frame store at rotated addresses
// and drains the rotated frame in raster order.
// ============================================================================
//
//  Channel  Ports                          Flow
//  -------  -----------------------------  ----------------------------------
//  request  start, busy, req_item          load byte or drain request in
//  result   rsp_strobe, rsp_item           rotated byte and last flag out
//  config   csr_we, csr_index, csr_wdata   register write, no wait
//
// One request is taken per cycle while busy is low; a load writes the frame
// store in the cycle it is accepted through the single write port.
// A drain reads the store and its result appears in the next cycle, for one
// cycle, from the registered read port; the receiver cannot stall it.
// Busy is high after reset and after each register write, while the frame
// area and byte count are recomputed.
// The store is not cleared: a drain only reaches bytes loaded for the frame.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module image_right_angle_rotator_unit #(
   parameter int MAX_WIDTH    = iarr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = iarr_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_CHANNELS = iarr_pkg::DEF_MAX_CHANNELS
) (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   input  wire  logic                                start,
   output logic                                      busy,
   input  wire  iarr_pkg::req_type                   req_item,
   output logic                                      rsp_strobe,
   output iarr_pkg::rsp_type                         rsp_item,
   input  wire  logic                                csr_we,
   input  wire  logic [iarr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  logic [iarr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DIM_W_W = $clog2(MAX_WIDTH + 1);
   localparam int DIM_H_W = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
   localparam int WH_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TOT_W   = $clog2(DEPTH + 1);
   localparam int SET_W   = $clog2(iarr_pkg::SETUP_CYCLES + 1);

   logic [7:0]       width_cfg_ff, width_cfg_in;
   logic [7:0]       height_cfg_ff, height_cfg_in;
   logic [2:0]       chans_cfg_ff, chans_cfg_in;
   logic [1:0]       mode_ff, mode_in;
   logic [SET_W-1:0] setup_ff, setup_in;
   logic             ready_ff, ready_in;
   logic [ADDR_W-1:0] drain_idx_ff, drain_idx_in;
   logic             rsp_pend_ff, rsp_last_ff;
   logic [WH_W-1:0]  area_ff;
   logic [TOT_W-1:0] total_ff;

   logic [DIM_W_W-1:0] width_eff;
   logic [DIM_H_W-1:0] height_eff;
   logic [CNT_W-1:0]   chans_eff;
   logic               cfg_hit, accept, load_go, drain_go, drain_last;
   logic [TOT_W-1:0]   idx_next;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         rd_data;
   iarr_pkg::ldc_type  ldc;
   iarr_pkg::lds_type  lds;

   // Register writes; every index names a register.
   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      chans_cfg_in  = chans_cfg_ff;
      mode_in       = mode_ff;
      cfg_hit       = csr_we;
      if (csr_we) begin
         unique case (csr_index)
            iarr_pkg::REG_IMAGE_WIDTH:   width_cfg_in  = csr_wdata;
            iarr_pkg::REG_IMAGE_HEIGHT:  height_cfg_in = csr_wdata;
            iarr_pkg::REG_CHANNEL_COUNT: chans_cfg_in  = csr_wdata[2:0];
            iarr_pkg::REG_ROTATION_MODE: mode_in       = csr_wdata[1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= 8'd1;
         height_cfg_ff <= 8'd1;
         chans_cfg_ff  <= 3'd1;
         mode_ff       <= iarr_pkg::ROT_90;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         chans_cfg_ff  <= chans_cfg_in;
         mode_ff       <= mode_in;
      end
   end

   // Dimensions in use: zero counts as one and large values saturate.
   always_comb begin
      if (width_cfg_ff == 8'd0) begin
         width_eff = DIM_W_W'(1);
      end else if (32'(width_cfg_ff) > MAX_WIDTH) begin
         width_eff = DIM_W_W'(MAX_WIDTH);
      end else begin
         width_eff = DIM_W_W'(width_cfg_ff);
      end
      if (height_cfg_ff == 8'd0) begin
         height_eff = DIM_H_W'(1);
      end else if (32'(height_cfg_ff) > MAX_HEIGHT) begin
         height_eff = DIM_H_W'(MAX_HEIGHT);
      end else begin
         height_eff = DIM_H_W'(height_cfg_ff);
      end
      if (chans_cfg_ff == 3'd0) begin
         chans_eff = CNT_W'(1);
      end else if (32'(chans_cfg_ff) > MAX_CHANNELS) begin
         chans_eff = CNT_W'(MAX_CHANNELS);
      end else begin
         chans_eff = CNT_W'(chans_cfg_ff);
      end
   end

   // Frame area and byte count, one multiplication per stage.
   always_ff @(posedge clock) begin
      area_ff  <= WH_W'(width_eff) * WH_W'(height_eff);
      total_ff <= TOT_W'(area_ff) * TOT_W'(chans_eff);
   end

   // Setup countdown after reset and after each register write.
   always_comb begin
      if (cfg_hit) begin
         setup_in = SET_W'(iarr_pkg::SETUP_CYCLES);
      end else if (setup_ff != '0) begin
         setup_in = setup_ff - SET_W'(1);
      end else begin
         setup_in = setup_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff <= SET_W'(iarr_pkg::SETUP_CYCLES);
      end else begin
         setup_ff <= setup_in;
      end
   end

   assign busy     = (setup_ff != '0);
   assign accept   = start && !busy;
   assign load_go  = accept && (req_item.func == iarr_pkg::FUNC_LOAD);
   assign drain_go = accept && (req_item.func == iarr_pkg::FUNC_DRAIN) && ready_ff;

   // Load address generator.
   always_comb begin
      ldc.load    = load_go;
      ldc.restart = cfg_hit;
      ldc.reload  = busy;
   end

   iarr_load_addr #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_load_addr (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ldc),
      .width   (width_eff),
      .height  (height_eff),
      .chans   (chans_eff),
      .mode    (mode_ff),
      .area    (area_ff),
      .status  (lds),
      .wr_addr (wr_addr)
   );

   // Frame store.
   iarr_ram #(
      .DATA_W (8),
      .DEPTH  (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (wr_addr),
      .wr_data (req_item.sample),
      .rd_en   (drain_go),
      .rd_addr (drain_idx_ff),
      .rd_data (rd_data)
   );

   // Drain position and frame-ready flag.
   always_comb begin
      idx_next   = TOT_W'(drain_idx_ff) + TOT_W'(1);
      drain_last = (idx_next >= total_ff);
      ready_in     = ready_ff;
      drain_idx_in = drain_idx_ff;
      if (cfg_hit) begin
         ready_in     = 1'b0;
         drain_idx_in = '0;
      end else if (load_go) begin
         // A load always opens or continues a frame being filled.
         ready_in     = lds.frame_done;
         drain_idx_in = '0;
      end else if (drain_go) begin
         ready_in     = !drain_last;
         drain_idx_in = drain_last ? '0 : ADDR_W'(idx_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         drain_idx_ff <= '0;
         rsp_pend_ff  <= 1'b0;
      end else begin
         ready_ff     <= ready_in;
         drain_idx_ff <= drain_idx_in;
         rsp_pend_ff  <= drain_go;
      end
   end

   always_ff @(posedge clock) begin
      if (drain_go) begin
         rsp_last_ff <= drain_last;
      end
   end

   // Result: the byte comes straight from the registered read port.
   always_comb begin
      rsp_strobe          = rsp_pend_ff;
      rsp_item.pixel_byte = rd_data;
      rsp_item.last_byte  = rsp_last_ff;
   end

   // A result only follows a drain accepted while the frame was ready.
   a_rsp_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && ready_ff &&
                           req_item.func == iarr_pkg::FUNC_DRAIN))
      else $error("result without a drain on a ready frame");

   // The final byte of a frame leaves the frame no longer ready.
   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last_byte |-> !ready_ff)
      else $error("frame still ready after its final byte");

   // A register write restarts the frame and holds requests off during setup.
   a_cfg_restart : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy && !ready_ff && drain_idx_ff == '0)
      else $error("register write did not restart the frame");

   // A load always rewinds the drain position.
   a_load_rewind : assert property (@(posedge clock) disable iff (reset)
      load_go && !csr_we |=> drain_idx_ff == '0)
      else $error("drain position not rewound by a load");

endmodule

`default_nettype wire
